// File: rtl/core/mer_pkg.sv
// Shared types and constants for the midpoint ellipse rasterizer.
// No dependencies; every rtl/core module imports this package.
package mer_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = 12;
  localparam int OUT_BITS    = 14;
  localparam int TERM_BITS   = 64;

  // rx^2, ry^2 and the widest multiplier operand (an odd 2x+1 squared)
  localparam int SQ_BITS = 2 * RADIUS_BITS;
  localparam int MUL_W   = 2 * RADIUS_BITS + 2;
  localparam int PROD_W  = 2 * MUL_W;

  localparam int IN_FIELDS_W  = 2 * COORD_BITS;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4 * OUT_BITS + 2 * RADIUS_BITS;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    TERM_PROD,
    TERM_PROD_X2,
    TERM_PROD_X4,
    TERM_A2,
    TERM_B2,
    TERM_A2_Q
  } term_sel_t;

  typedef struct packed {
    logic      en;
    logic      clr;      // start from zero instead of the held term
    logic      sub;
    logic      quarter;  // divide by 4, truncating toward zero
    term_sel_t sel;
  } acc_ctrl_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] px_right;
    logic signed [OUT_BITS-1:0] px_left;
    logic signed [OUT_BITS-1:0] py_low;
    logic signed [OUT_BITS-1:0] py_high;
    logic [RADIUS_BITS-1:0]     offset_x;
    logic [RADIUS_BITS-1:0]     offset_y;
    logic                       in_region_two;
    logic                       last_point;
  } point_t;

endpackage

// File: rtl/core/mer_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on mer_pkg.
module mer_mul (
  input  logic                       clk,
  input  logic [mer_pkg::MUL_W-1:0]  mul_a,
  input  logic [mer_pkg::MUL_W-1:0]  mul_b,
  output logic [mer_pkg::PROD_W-1:0] prod
);
  import mer_pkg::*;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign prod = prod_r;

endmodule

// File: rtl/core/mer_acc.sv
// Decision-term accumulator: one 64-bit add/subtract of a selected operand.
// Depends on mer_pkg; fed by the registered product of mer_mul.
module mer_acc (
  input  logic                        clk,
  input  mer_pkg::acc_ctrl_t          ctrl,
  input  logic [mer_pkg::PROD_W-1:0]  prod,
  input  logic [mer_pkg::SQ_BITS-1:0] a2,
  input  logic [mer_pkg::SQ_BITS-1:0] b2,
  output logic                        term_pos
);
  import mer_pkg::*;

  logic [TERM_BITS-1:0] dt_r;
  logic [TERM_BITS-1:0] dt_nxt;
  logic [TERM_BITS-1:0] base;
  logic [TERM_BITS-1:0] term;
  logic [TERM_BITS-1:0] sum;

  always_comb begin
    case (ctrl.sel)
      TERM_PROD:    term = TERM_BITS'(prod);
      TERM_PROD_X2: term = TERM_BITS'({prod, 1'b0});
      TERM_PROD_X4: term = TERM_BITS'({prod, 2'b00});
      TERM_A2:      term = TERM_BITS'(a2);
      TERM_B2:      term = TERM_BITS'(b2);
      TERM_A2_Q:    term = TERM_BITS'(a2 >> 2);
      default:      term = '0;
    endcase
    // negative values get +3 before the shift so the quotient rounds to zero
    if (ctrl.quarter) begin
      term = dt_r[TERM_BITS-1] ? TERM_BITS'(3) : '0;
    end
    base = ctrl.clr ? '0 : dt_r;
    sum  = base + (ctrl.sub ? ~term : term) + TERM_BITS'(ctrl.sub);
    if (ctrl.quarter) begin
      dt_nxt = TERM_BITS'($signed(sum) >>> 2);
    end else begin
      dt_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      dt_r <= dt_nxt;
    end
  end

  assign term_pos = (dt_r != '0) && !dt_r[TERM_BITS-1];

endmodule

// File: rtl/core/mer_seq.sv
// Sequencer: runs one start or step item as a series of multiply and
// accumulate steps on the shared units; holds position, region and centre.
// Depends on mer_pkg; drives mer_mul and mer_acc.
module mer_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_op,
  input  logic [mer_pkg::COORD_BITS-1:0] in_cx,
  input  logic [mer_pkg::COORD_BITS-1:0] in_cy,
  input  logic [mer_pkg::RADIUS_BITS-1:0] rx,
  input  logic [mer_pkg::RADIUS_BITS-1:0] ry,
  input  logic [mer_pkg::PROD_W-1:0]     prod,
  input  logic                           term_pos,
  input  logic                           out_free,
  output logic                           ready,
  output logic [mer_pkg::MUL_W-1:0]      mul_a,
  output logic [mer_pkg::MUL_W-1:0]      mul_b,
  output mer_pkg::acc_ctrl_t             acc_ctrl,
  output logic [mer_pkg::SQ_BITS-1:0]    a2,
  output logic [mer_pkg::SQ_BITS-1:0]    b2,
  output logic                           emit,
  output mer_pkg::point_t                point
);
  import mer_pkg::*;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_SQA, S_SQB, S_SQC,
    S_ST_ACC, S_ST_B2, S_ST_AQ,
    S_R0_CMP1, S_R0_CMP2, S_R0_MX, S_R0_A1, S_R0_A2, S_R0_MY, S_R0_A3,
    S_RC_SQ, S_RC_SQ2, S_RC_TX, S_RC_TX2, S_RC_AB, S_RC_AB2, S_RC_Q,
    S_R2_0, S_R2_MY, S_R2_A1, S_R2_A2, S_R2_MX, S_R2_A3,
    S_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   op_r, op_nxt;
  logic [RADIUS_BITS-1:0] x_r, x_nxt;
  logic [RADIUS_BITS-1:0] y_r, y_nxt;
  logic                   region_r, region_nxt;
  logic                   busy_r, busy_nxt;
  logic                   pos_r, pos_nxt;
  logic [COORD_BITS-1:0]  cx_r, cx_nxt;
  logic [COORD_BITS-1:0]  cy_r, cy_nxt;
  logic [SQ_BITS-1:0]     a2_r, a2_nxt;
  logic [SQ_BITS-1:0]     b2_r, b2_nxt;
  logic [PROD_W-1:0]      cmp_r, cmp_nxt;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    region_nxt = region_r;
    busy_nxt   = busy_r;
    pos_nxt    = pos_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    a2_nxt     = a2_r;
    b2_nxt     = b2_r;
    cmp_nxt    = cmp_r;
    mul_a      = '0;
    mul_b      = '0;
    acc_ctrl.en      = 1'b0;
    acc_ctrl.clr     = 1'b0;
    acc_ctrl.sub     = 1'b0;
    acc_ctrl.quarter = 1'b0;
    acc_ctrl.sel     = TERM_PROD;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_op;
          if (in_op == OP_START) begin
            cx_nxt    = in_cx;
            cy_nxt    = in_cy;
            state_nxt = S_SQA;
          end else if (busy_r) begin
            state_nxt = S_SQA;
          end
        end
      end
      S_SQA: begin
        mul_a     = MUL_W'(rx);
        mul_b     = MUL_W'(rx);
        state_nxt = S_SQB;
      end
      S_SQB: begin
        a2_nxt    = prod[SQ_BITS-1:0];
        mul_a     = MUL_W'(ry);
        mul_b     = MUL_W'(ry);
        state_nxt = S_SQC;
      end
      S_SQC: begin
        b2_nxt = prod[SQ_BITS-1:0];
        if (op_r == OP_START) begin
          mul_a     = MUL_W'(a2_r);
          mul_b     = MUL_W'(ry);
          state_nxt = S_ST_ACC;
        end else if (!region_r) begin
          mul_a     = MUL_W'(a2_r);
          mul_b     = MUL_W'(y_r);
          state_nxt = S_R0_CMP1;
        end else begin
          state_nxt = S_R2_0;
        end
      end
      // start: ry^2 - rx^2*ry + rx^2/4
      S_ST_ACC: begin
        acc_ctrl.en  = 1'b1;
        acc_ctrl.clr = 1'b1;
        acc_ctrl.sub = 1'b1;
        acc_ctrl.sel = TERM_PROD;
        state_nxt    = S_ST_B2;
      end
      S_ST_B2: begin
        acc_ctrl.en  = 1'b1;
        acc_ctrl.sel = TERM_B2;
        state_nxt    = S_ST_AQ;
      end
      S_ST_AQ: begin
        acc_ctrl.en  = 1'b1;
        acc_ctrl.sel = TERM_A2_Q;
        x_nxt        = '0;
        y_nxt        = ry;
        region_nxt   = 1'b0;
        state_nxt    = S_EMIT;
      end
      // region one: compare ry^2*x against rx^2*y
      S_R0_CMP1: begin
        cmp_nxt   = prod;
        mul_a     = MUL_W'(b2_r);
        mul_b     = MUL_W'(x_r);
        state_nxt = S_R0_CMP2;
      end
      S_R0_CMP2: begin
        if (prod < cmp_r) begin
          x_nxt     = x_r + 1'b1;
          pos_nxt   = term_pos;
          state_nxt = S_R0_MX;
        end else begin
          state_nxt = S_RC_SQ;
        end
      end
      S_R0_MX: begin
        mul_a     = MUL_W'(b2_r);
        mul_b     = MUL_W'(x_r);
        state_nxt = S_R0_A1;
      end
      S_R0_A1: begin
        acc_ctrl.en  = 1'b1;
        acc_ctrl.sel = TERM_PROD_X2;
        state_nxt    = S_R0_A2;
      end
      S_R0_A2: begin
        acc_ctrl.en  = 1'b1;
        acc_ctrl.sel = TERM_B2;
        if (pos_r) begin
          y_nxt     = y_r - 1'b1;
          state_nxt = S_R0_MY;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_R0_MY: begin
        mul_a     = MUL_W'(a2_r);
        mul_b     = MUL_W'(y_r);
        state_nxt = S_R0_A3;
      end
      S_R0_A3: begin
        acc_ctrl.en  = 1'b1;
        acc_ctrl.sub = 1'b1;
        acc_ctrl.sel = TERM_PROD_X2;
        state_nxt    = S_EMIT;
      end
      // region change, in quarters: 4a2(y-1)^2 + b2(2x+1)^2 - 4a2b2
      S_RC_SQ: begin
        mul_a     = MUL_W'(RADIUS_BITS'(y_r - 1'b1));
        mul_b     = MUL_W'(RADIUS_BITS'(y_r - 1'b1));
        state_nxt = S_RC_SQ2;
      end
      S_RC_SQ2: begin
        mul_a     = MUL_W'(a2_r);
        mul_b     = prod[MUL_W-1:0];
        state_nxt = S_RC_TX;
      end
      S_RC_TX: begin
        acc_ctrl.en  = 1'b1;
        acc_ctrl.clr = 1'b1;
        acc_ctrl.sel = TERM_PROD_X4;
        mul_a        = MUL_W'({x_r, 1'b1});
        mul_b        = MUL_W'({x_r, 1'b1});
        state_nxt    = S_RC_TX2;
      end
      S_RC_TX2: begin
        mul_a     = MUL_W'(b2_r);
        mul_b     = prod[MUL_W-1:0];
        state_nxt = S_RC_AB;
      end
      S_RC_AB: begin
        acc_ctrl.en  = 1'b1;
        acc_ctrl.sel = TERM_PROD;
        mul_a        = MUL_W'(a2_r);
        mul_b        = MUL_W'(b2_r);
        state_nxt    = S_RC_AB2;
      end
      S_RC_AB2: begin
        acc_ctrl.en  = 1'b1;
        acc_ctrl.sub = 1'b1;
        acc_ctrl.sel = TERM_PROD_X4;
        state_nxt    = S_RC_Q;
      end
      S_RC_Q: begin
        acc_ctrl.en      = 1'b1;
        acc_ctrl.quarter = 1'b1;
        region_nxt       = 1'b1;
        state_nxt        = S_R2_0;
      end
      // region two iteration; sign is taken before the update
      S_R2_0: begin
        y_nxt     = y_r - 1'b1;
        pos_nxt   = term_pos;
        state_nxt = S_R2_MY;
      end
      S_R2_MY: begin
        mul_a     = MUL_W'(a2_r);
        mul_b     = MUL_W'(y_r);
        state_nxt = S_R2_A1;
      end
      S_R2_A1: begin
        acc_ctrl.en  = 1'b1;
        acc_ctrl.sub = 1'b1;
        acc_ctrl.sel = TERM_PROD_X2;
        state_nxt    = S_R2_A2;
      end
      S_R2_A2: begin
        acc_ctrl.en  = 1'b1;
        acc_ctrl.sel = TERM_A2;
        if (pos_r) begin
          state_nxt = S_EMIT;
        end else begin
          x_nxt     = x_r + 1'b1;
          state_nxt = S_R2_MX;
        end
      end
      S_R2_MX: begin
        mul_a     = MUL_W'(b2_r);
        mul_b     = MUL_W'(x_r);
        state_nxt = S_R2_A3;
      end
      S_R2_A3: begin
        acc_ctrl.en  = 1'b1;
        acc_ctrl.sel = TERM_PROD_X2;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          busy_nxt  = (y_r != '0);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      region_r <= 1'b0;
      busy_r   <= 1'b0;
      x_r      <= '0;
      y_r      <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      region_r <= region_nxt;
      busy_r   <= busy_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
    end
    op_r  <= op_nxt;
    pos_r <= pos_nxt;
    a2_r  <= a2_nxt;
    b2_r  <= b2_nxt;
    cmp_r <= cmp_nxt;
  end

  assign ready = (state_r == S_IDLE);
  assign emit  = (state_r == S_EMIT) && out_free;
  assign a2    = a2_r;
  assign b2    = b2_r;

  assign point.px_right      = $signed(OUT_BITS'(cx_r) + OUT_BITS'(x_r));
  assign point.px_left       = $signed(OUT_BITS'(cx_r) - OUT_BITS'(x_r));
  assign point.py_low        = $signed(OUT_BITS'(cy_r) + OUT_BITS'(y_r));
  assign point.py_high       = $signed(OUT_BITS'(cy_r) - OUT_BITS'(y_r));
  assign point.offset_x      = x_r;
  assign point.offset_y      = y_r;
  assign point.in_region_two = region_r;
  assign point.last_point    = (y_r == '0);

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_valid) |=> ($stable(x_r) && $stable(y_r) && $stable(busy_r)))
    else $error("position or busy changed while idle");

  a_last_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && y_r == '0) |=> !busy_r)
    else $error("busy still set after the last point");

  a_region_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(region_r) |-> $past(state_r) == S_RC_Q)
    else $error("region two entered outside the region change");

  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_op == OP_STEP && !busy_r) |=> state_r == S_IDLE)
    else $error("step while idle started a sequence");

endmodule

// File: rtl/core/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer: each start or step item runs as a sequence of
// multiply and accumulate states, a step taking the longer path when both x and
// y move and the step that changes region also reloading the term; the result
// then waits on out_tready. A step with no ellipse in progress gives no result.
// One item at a time: the next item is taken the cycle after its result is
// registered. Reset (rst_n low, synchronous) clears radii, position and busy.
module midpoint_ellipse_rasterizer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mer_pkg::IN_DATA_W-1:0]  in_tdata,   // centre_x, centre_y
  input  logic                           in_tuser,   // opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // px_right, px_left, py_low, py_high, offset_x, offset_y, zero pad
  output logic [mer_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser,  // in_region_two
  output logic                           out_tlast,  // last_point
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [mer_pkg::RADIUS_BITS-1:0] cfg_wdata
);
  import mer_pkg::*;

  localparam logic CFG_RADIUS_X = 1'b0;
  localparam logic CFG_RADIUS_Y = 1'b1;

  logic [RADIUS_BITS-1:0] rx_r;
  logic [RADIUS_BITS-1:0] ry_r;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic                   out_user_r;
  logic                   out_last_r;

  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod;
  acc_ctrl_t          acc_ctrl;
  logic [SQ_BITS-1:0] a2;
  logic [SQ_BITS-1:0] b2;
  logic               term_pos;
  logic               out_free;
  logic               emit;
  point_t             point;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r <= '0;
      ry_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS_X: rx_r <= cfg_wdata;
        CFG_RADIUS_Y: ry_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_tready;

  mer_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_cx    (in_tdata[COORD_BITS-1:0]),
    .in_cy    (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .rx       (rx_r),
    .ry       (ry_r),
    .prod     (prod),
    .term_pos (term_pos),
    .out_free (out_free),
    .ready    (in_tready),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .acc_ctrl (acc_ctrl),
    .a2       (a2),
    .b2       (b2),
    .emit     (emit),
    .point    (point)
  );

  mer_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  mer_acc u_acc (
    .clk      (clk),
    .ctrl     (acc_ctrl),
    .prod     (prod),
    .a2       (a2),
    .b2       (b2),
    .term_pos (term_pos)
  );

  // result register; the next item may run while this one waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (emit) begin
      out_data_r <= OUT_DATA_W'({point.offset_y, point.offset_x, point.py_high,
                                 point.py_low, point.px_left, point.px_right});
      out_user_r <= point.in_region_two;
      out_last_r <= point.last_point;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// File: tb/sv/mer_tb_pkg.sv
// Register indexes and opcodes for the ellipse rasterizer testbench.
// Shared by the checker and the testbench top; no dependencies.
package mer_tb_pkg;

  typedef enum logic {
    REG_RADIUS_X = 1'b0,
    REG_RADIUS_Y = 1'b1
  } mer_reg_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } mer_op_t;

endpackage

// File: tb/sv/mer_point_checker.sv
// Watches the item, point and register ports of the ellipse rasterizer,
// predicts every point and compares it field by field. Uses mer_pkg, mer_tb_pkg.
module mer_point_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [mer_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [mer_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             out_tuser,
  input  logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [mer_pkg::RADIUS_BITS-1:0]  cfg_wdata,
  output int                               mismatch_count,
  output int                               points_pending,
  output int                               points_predicted
);
  import mer_pkg::*;
  import mer_tb_pkg::*;

  localparam logic [63:0] TERM_SIGN = 64'h8000_0000_0000_0000;

  logic [RADIUS_BITS-1:0] rad_x, rad_y;
  logic [RADIUS_BITS-1:0] pos_x, pos_y;
  logic [63:0]            term;
  logic                   region_two;
  logic                   drawing;
  logic [COORD_BITS-1:0]  held_cx, held_cy;

  point_t pending_points[$];

  function automatic bit term_positive(input logic [63:0] v);
    return (v != 64'd0) && ((v & TERM_SIGN) == 64'd0);
  endfunction

  // two's complement divide by 4, truncating toward zero
  function automatic logic [63:0] quarter_toward_zero(input logic [63:0] v);
    logic [63:0] mag;
    if (v[63]) begin
      mag = (~v + 64'd1) >> 2;
      return ~mag + 64'd1;
    end
    return v >> 2;
  endfunction

  function automatic point_t current_point();
    point_t pt;
    logic [OUT_BITS-1:0] cx, cy, ox, oy;
    cx = {{(OUT_BITS-COORD_BITS){1'b0}}, held_cx};
    cy = {{(OUT_BITS-COORD_BITS){1'b0}}, held_cy};
    ox = {{(OUT_BITS-RADIUS_BITS){1'b0}}, pos_x};
    oy = {{(OUT_BITS-RADIUS_BITS){1'b0}}, pos_y};
    pt.px_right      = cx + ox;
    pt.px_left       = cx - ox;
    pt.py_low        = cy + oy;
    pt.py_high       = cy - oy;
    pt.offset_x      = pos_x;
    pt.offset_y      = pos_y;
    pt.in_region_two = region_two;
    pt.last_point    = (pos_y == '0);
    if (pos_y == '0)
      drawing = 1'b0;
    return pt;
  endfunction

  // Apply one item to the shadow state; returns 1 when it yields a point.
  function automatic bit advance_ellipse(input logic op, input logic [COORD_BITS-1:0] cx,
                                         input logic [COORD_BITS-1:0] cy, output point_t pt);
    logic [63:0] a2, b2, x64, y64, ym1, tx, q;
    a2 = {54'd0, rad_x} * {54'd0, rad_x};
    b2 = {54'd0, rad_y} * {54'd0, rad_y};
    if (op == OP_START) begin
      held_cx    = cx;
      held_cy    = cy;
      pos_x      = '0;
      pos_y      = rad_y;
      term       = b2 - a2 * {54'd0, rad_y} + (a2 >> 2);
      region_two = 1'b0;
      drawing    = 1'b1;
      pt = current_point();
      return 1'b1;
    end
    if (!drawing)
      return 1'b0;
    x64 = {54'd0, pos_x};
    y64 = {54'd0, pos_y};
    if (!region_two) begin
      if (b2 * x64 < a2 * y64) begin
        pos_x = pos_x + 1'b1;
        x64   = {54'd0, pos_x};
        if (!term_positive(term)) begin
          term = term + 2 * b2 * x64 + b2;
        end else begin
          pos_y = pos_y - 1'b1;
          y64   = {54'd0, pos_y};
          term  = term + 2 * b2 * x64 - 2 * a2 * y64 + b2;
        end
        pt = current_point();
        return 1'b1;
      end
      // region change: reload the term in quarters, then one region-two pass
      ym1 = y64 - 64'd1;
      tx  = 2 * x64 + 64'd1;
      q   = 4 * a2 * ym1 * ym1 + b2 * tx * tx - 4 * a2 * b2;
      term       = quarter_toward_zero(q);
      region_two = 1'b1;
    end
    pos_y = pos_y - 1'b1;
    y64   = {54'd0, pos_y};
    if (term_positive(term)) begin
      term = term + a2 - 2 * a2 * y64;
    end else begin
      pos_x = pos_x + 1'b1;
      x64   = {54'd0, pos_x};
      term  = term + 2 * b2 * x64 - 2 * a2 * y64 + a2;
    end
    pt = current_point();
    return 1'b1;
  endfunction

  task automatic report_point(input string what, input point_t want, input point_t seen);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s at %0t", what, $time);
      $display("  expected: pxr=%0d pxl=%0d pyl=%0d pyh=%0d x=%0d y=%0d r2=%0b last=%0b",
               want.px_right, want.px_left, want.py_low, want.py_high,
               want.offset_x, want.offset_y, want.in_region_two, want.last_point);
      $display("  actual:   pxr=%0d pxl=%0d pyl=%0d pyh=%0d x=%0d y=%0d r2=%0b last=%0b",
               seen.px_right, seen.px_left, seen.py_low, seen.py_high,
               seen.offset_x, seen.offset_y, seen.in_region_two, seen.last_point);
    end
  endtask

  always @(posedge clk) begin : monitor
    point_t seen, want;
    if (!rst_n) begin
      rad_x = '0; rad_y = '0; pos_x = '0; pos_y = '0; term = '0;
      region_two = 1'b0; drawing = 1'b0; held_cx = '0; held_cy = '0;
      pending_points.delete();
      mismatch_count = 0; points_pending = 0; points_predicted = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_RADIUS_X)
          rad_x = cfg_wdata;
        else
          rad_y = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        seen.px_right      = out_tdata[OUT_BITS-1:0];
        seen.px_left       = out_tdata[2*OUT_BITS-1:OUT_BITS];
        seen.py_low        = out_tdata[3*OUT_BITS-1:2*OUT_BITS];
        seen.py_high       = out_tdata[4*OUT_BITS-1:3*OUT_BITS];
        seen.offset_x      = out_tdata[4*OUT_BITS+RADIUS_BITS-1:4*OUT_BITS];
        seen.offset_y      = out_tdata[4*OUT_BITS+2*RADIUS_BITS-1:4*OUT_BITS+RADIUS_BITS];
        seen.in_region_two = out_tuser;
        seen.last_point    = out_tlast;
        if (pending_points.size() == 0) begin
          want = '0;
          report_point("Unexpected point", want, seen);
        end else begin
          want = pending_points.pop_front();
          if (seen.px_right !== want.px_right || seen.px_left !== want.px_left ||
              seen.py_low !== want.py_low || seen.py_high !== want.py_high ||
              seen.offset_x !== want.offset_x || seen.offset_y !== want.offset_y ||
              seen.in_region_two !== want.in_region_two ||
              seen.last_point !== want.last_point)
            report_point("Point mismatch", want, seen);
        end
      end
      if (in_tvalid && in_tready) begin
        if (advance_ellipse(in_tuser, in_tdata[COORD_BITS-1:0],
                            in_tdata[2*COORD_BITS-1:COORD_BITS], want)) begin
          pending_points.push_back(want);
          points_predicted++;
        end
      end
      points_pending = pending_points.size();
    end
  end

endmodule

// File: tb/sv/midpoint_ellipse_rasterizer_tb.sv
// Testbench top for the midpoint ellipse rasterizer: clock, reset, register
// writes, item stimulus and the verdict. Uses mer_pkg, mer_tb_pkg, mer_point_checker.
module midpoint_ellipse_rasterizer_tb;
  import mer_pkg::*;
  import mer_tb_pkg::*;

  localparam int SETTLE_CYCLES = 25;  // longer than the slowest item
  localparam int HOLD_CYCLES   = 300;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic                   cfg_index  = 1'b0;
  logic [RADIUS_BITS-1:0] cfg_wdata  = '0;

  int mismatch_count, points_pending, points_predicted;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int items_sent = 0;
  int radius_settings = 0;
  logic [RADIUS_BITS-1:0] cur_rx = '0, cur_ry = '0;

  midpoint_ellipse_rasterizer i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  mer_point_checker i_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_we, .cfg_index, .cfg_wdata,
    .mismatch_count, .points_pending, .points_predicted
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #(12 * 400000);
    $display("Timeout at %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_item(input mer_op_t op, input logic [COORD_BITS-1:0] cx,
                           input logic [COORD_BITS-1:0] cy);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {cy, cx};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic push_steps(input int n);
    repeat (n) push_item(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  // sender pauses until every point is in, then the block gets time to settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (points_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_radii(input logic [RADIUS_BITS-1:0] rx, input logic [RADIUS_BITS-1:0] ry);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_RADIUS_X;
    cfg_wdata <= rx;
    @(negedge clk);
    cfg_index <= REG_RADIUS_Y;
    cfg_wdata <= ry;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_rx = rx;
    cur_ry = ry;
    radius_settings++;
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return COORD_BITS'($urandom);
  endfunction

  function automatic logic [RADIUS_BITS-1:0] pick_radius();
    int sel;
    sel = $urandom_range(99);
    if (sel < 6)  return '0;
    if (sel < 10) return '1;
    if (sel < 14) return RADIUS_BITS'($urandom_range(65, 1022));
    return RADIUS_BITS'($urandom_range(1, 24));
  endfunction

  // mostly whole ellipses; big radii and some small ones only partly drawn
  task automatic run_stage(input int tx_pct, input int rx_pct, input int n_items);
    int goal, sel, nsteps;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        write_radii(pick_radius(), pick_radius());
        // keep drawing the old ellipse with the new radii
        if ($urandom_range(1)) push_steps($urandom_range(1, 8));
      end else if (sel < 18) begin
        push_steps($urandom_range(1, 3));
      end else begin
        push_item(OP_START, pick_coord(), pick_coord());
        if (cur_rx <= 64 && cur_ry <= 64 && $urandom_range(3) != 0)
          nsteps = int'(cur_rx) + int'(cur_ry) + 2;
        else
          nsteps = $urandom_range(0, 40);
        push_steps(nsteps);
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    tx_idle_pct = 15;
    rx_idle_pct <= 61;

    // zero radii: the start point is already the last one; a step then does nothing
    write_radii('0, '0);
    push_item(OP_START, '0, '0);
    push_item(OP_STEP, '1, '1);
    // zero rx skips region one
    write_radii('0, 10'd3);
    push_item(OP_START, '1, '1);
    push_steps(4);
    // largest radii, then a start that abandons the ellipse in progress
    write_radii('1, '1);
    push_item(OP_START, '0, '1);
    push_steps(3);
    push_item(OP_START, '1, '0);
    push_steps(2);
    // radii changed while an ellipse is still being drawn
    write_radii(10'd7, 10'd5);
    push_steps(3);
    write_radii(10'd3, 10'd2);
    push_item(OP_START, 12'd2048, 12'd1365);
    push_steps(7);

    run_stage(15, 61, 180);
    run_stage(61, 15, 180);

    // long receiver hold-off while items keep coming
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    write_radii(10'd20, 10'd12);
    hold_request <= 1'b1;
    push_item(OP_START, pick_coord(), pick_coord());
    push_steps(24);
    drain();
    run_stage(0, 0, 180);
    drain();

    $display("Ran %0d items through %0d radius settings, %0d points checked.",
             items_sent, radius_settings, points_predicted);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
